### sv/pli_pkg.sv
// Shared constants and types for the piecewise-linear interpolator.
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_QUERY_X = 2'd1,
        MODE_QUERY_Y = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FEW       = 2'd1,
        ST_ZERO_SEG  = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    localparam logic [PADDR_W-1:0] ADDR_POINT_COUNT = '0;

endpackage

### sv/pli_div.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module pli_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2*pli_pkg::DATA_W-1:0]  dividend,
    input  logic [pli_pkg::DATA_W-1:0]    divisor,
    output logic                          done,
    output logic [2*pli_pkg::DATA_W-1:0]  quotient
);

    localparam int W = pli_pkg::DATA_W;

    logic [2*W-1:0] quo_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   dvs_reg;
    logic [6:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [W:0]     rem_sh;
    logic           fits;
    logic [W:0]     rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[2*W-1]};
        fits    = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= 7'(2*W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
                quo_reg <= {quo_reg[2*W-2:0], fits};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/piecewise_linear_interpolator.sv
// Piecewise-linear lookup: breakpoint memory, sequential scan and iterative divide.
// For a query, the scan reads one breakpoint per cycle from the table memory, then a
// restoring divider produces the quotient. One item is worked at a time, and a result
// waiting on a stalled output holds off the next item.
// Reset clears point_count and the control state; the table memory is not cleared.
module piecewise_linear_interpolator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pli_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic [5:0]                        point_index,
    input  logic signed [31:0]                point_x,
    input  logic signed [31:0]                point_y,
    input  logic signed [31:0]                query_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                result_value,
    output logic [1:0]                        status
);

    localparam int W   = pli_pkg::DATA_W;
    localparam int IW  = pli_pkg::IDX_W;
    localparam int CW  = pli_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_SCAN, S_CALC, S_MUL, S_DIV, S_WAIT, S_FIN
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   point_count_reg;
    logic            sel_y_reg;
    logic [W-1:0]    q_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   last_reg;
    logic [2*W-1:0]  prev_reg;
    logic [2*W-1:0]  cur_reg;
    logic [W-1:0]    ma_reg, mb_reg, md_reg;
    logic            neg_reg;
    logic [2*W-1:0]  prod_reg;
    logic [W-1:0]    res_reg;
    logic [1:0]      st_reg;
    logic            out_valid_reg;
    logic [W-1:0]    out_res_reg;
    logic [1:0]      out_st_reg;

    // Table memory: x in the upper half, y in the lower half of each word.
    logic [2*W-1:0]  pt_mem [pli_pkg::MAX_POINTS];
    logic [2*W-1:0]  rdata_reg;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;

    logic            in_acc;
    logic            wr_cfg;
    logic [CW-1:0]   n_eff;
    logic [W-1:0]    key_cur;
    logic [W-1:0]    key_prev, val_prev, val_cur;
    logic signed [W:0] da, db, dd;
    logic [W:0]      abs_a, abs_b, abs_d;
    logic [2*W-1:0]  div_in;
    logic [2*W-1:0]  mq;
    logic signed [W+3:0] t;
    logic            div_start;
    logic            div_done;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign pready   = 1'b1;
    assign wr_cfg   = psel && penable && pwrite && pready && (paddr == pli_pkg::ADDR_POINT_COUNT);
    assign prdata   = (paddr == pli_pkg::ADDR_POINT_COUNT) ? {{(32-CW){1'b0}}, point_count_reg}
                                                           : 32'd0;

    assign n_eff = (point_count_reg > CW'(pli_pkg::MAX_POINTS)) ? CW'(pli_pkg::MAX_POINTS)
                                                                : point_count_reg;

    assign wr_en = in_acc && (mode == pli_pkg::MODE_WRITE);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_FIRST:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(1);
            end
            S_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + IW'(1);
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pt_mem[point_index] <= {point_x, point_y};
        if (rd_en)
            rdata_reg <= pt_mem[rd_addr];
    end

    always_comb
    begin
        key_cur  = sel_y_reg ? rdata_reg[W-1:0] : rdata_reg[2*W-1:W];
        key_prev = sel_y_reg ? prev_reg[W-1:0]  : prev_reg[2*W-1:W];
        val_prev = sel_y_reg ? prev_reg[2*W-1:W] : prev_reg[W-1:0];
        val_cur  = sel_y_reg ? cur_reg[2*W-1:W]  : cur_reg[W-1:0];
        da = $signed({q_reg[W-1], q_reg}) - $signed({key_prev[W-1], key_prev});
        db = $signed({val_cur[W-1], val_cur}) - $signed({val_prev[W-1], val_prev});
        dd = sel_y_reg
           ? $signed({cur_reg[W-1], cur_reg[W-1:0]}) - $signed({key_prev[W-1], key_prev})
           : $signed({cur_reg[2*W-1], cur_reg[2*W-1:W]}) - $signed({key_prev[W-1], key_prev});
        abs_a = da[W] ? (W+1)'(-da) : da;
        abs_b = db[W] ? (W+1)'(-db) : db;
        abs_d = dd[W] ? (W+1)'(-dd) : dd;
        div_in = prod_reg + {{W{1'b0}}, 1'b0, md_reg[W-1:1]};
        t = neg_reg ? $signed({{4{val_prev[W-1]}}, val_prev}) - $signed({2'b00, mq[W+1:0]})
                    : $signed({{4{val_prev[W-1]}}, val_prev}) + $signed({2'b00, mq[W+1:0]});
    end

    assign div_start = state_reg == S_DIV;

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .divisor  (md_reg),
        .done     (div_done),
        .quotient (mq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            sel_y_reg       <= 1'b0;
            q_reg           <= '0;
            idx_reg         <= '0;
            last_reg        <= '0;
            prev_reg        <= '0;
            cur_reg         <= '0;
            ma_reg          <= '0;
            mb_reg          <= '0;
            md_reg          <= '0;
            neg_reg         <= 1'b0;
            prod_reg        <= '0;
            res_reg         <= '0;
            st_reg          <= pli_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            out_res_reg     <= '0;
            out_st_reg      <= pli_pkg::ST_OK;
        end
        else
        begin
            if (wr_cfg)
                point_count_reg <= pwdata[CW-1:0];
            if (state_reg == S_FIN && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (mode == pli_pkg::MODE_QUERY_X || mode == pli_pkg::MODE_QUERY_Y))
                    begin
                        sel_y_reg <= mode == pli_pkg::MODE_QUERY_Y;
                        q_reg     <= query_value;
                        last_reg  <= IW'(n_eff - CW'(1));
                        if (n_eff < CW'(2))
                        begin
                            res_reg   <= '0;
                            st_reg    <= pli_pkg::ST_FEW;
                            state_reg <= S_FIN;
                        end
                        else
                            state_reg <= S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    prev_reg  <= rdata_reg;
                    idx_reg   <= IW'(1);
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg == last_reg || $signed(q_reg) <= $signed(key_cur))
                    begin
                        cur_reg   <= rdata_reg;
                        state_reg <= S_CALC;
                    end
                    else
                    begin
                        prev_reg <= rdata_reg;
                        idx_reg  <= idx_reg + IW'(1);
                    end
                end
                S_CALC:
                begin
                    if (dd == '0)
                    begin
                        res_reg   <= val_prev;
                        st_reg    <= pli_pkg::ST_ZERO_SEG;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        ma_reg    <= abs_a[W-1:0];
                        mb_reg    <= abs_b[W-1:0];
                        md_reg    <= abs_d[W-1:0];
                        neg_reg   <= (da[W] != db[W]) != dd[W];
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= ma_reg * mb_reg;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        // A quotient above 2^33 saturates outright; otherwise check the sum.
                        if (mq > (2*W)'(64'h2_0000_0000))
                        begin
                            res_reg <= neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                            st_reg  <= pli_pkg::ST_SATURATED;
                        end
                        else if (t > $signed({4'b0000, {(W-1){1'b1}}}))
                        begin
                            res_reg <= {1'b0, {(W-1){1'b1}}};
                            st_reg  <= pli_pkg::ST_SATURATED;
                        end
                        else if (t < $signed({4'b1111, 1'b1, {(W-1){1'b0}}}))
                        begin
                            res_reg <= {1'b1, {(W-1){1'b0}}};
                            st_reg  <= pli_pkg::ST_SATURATED;
                        end
                        else
                        begin
                            res_reg <= t[W-1:0];
                            st_reg  <= pli_pkg::ST_OK;
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_res_reg   <= res_reg;
                        out_st_reg    <= st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_res_reg;
    assign status       = out_st_reg;

endmodule

### tb/piecewise_linear_interpolator_test.sv
// Self-checking testbench for the piecewise-linear interpolator: random and directed items.
module piecewise_linear_interpolator_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         mode;
        logic [5:0]         index;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qv;
        bit                 is_cfg;
        logic [6:0]         cfg_count;
    } item_t;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         code;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [pli_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = pli_pkg::MODE_QUERY_X;
    logic [5:0] point_index = '0;
    logic signed [31:0] point_x = '0, point_y = '0, query_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] result_value;
    logic [1:0] status;

    piecewise_linear_interpolator i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    item_t   pending_items[$];
    lookup_t expected_lookups[$];
    logic signed [31:0] x_points[pli_pkg::MAX_POINTS];
    logic signed [31:0] y_points[pli_pkg::MAX_POINTS];
    logic [6:0] active_count;
    int errors = 0;
    int cycles = 0;
    int queries_checked = 0;
    int writes_sent = 0;
    int hold_off = 0;
    bit stimulus_done = 0;

    function automatic lookup_t interpolate(bit by_y, logic signed [31:0] q);
        lookup_t r;
        int n, i;
        longint k1, k2, v1, v2, dk, a, b, t;
        longint unsigned ma, mb, md, mq;
        bit neg;
        n = (active_count > pli_pkg::MAX_POINTS) ? pli_pkg::MAX_POINTS : active_count;
        r.code = pli_pkg::ST_OK;
        r.value = 0;
        if (n < 2)
        begin
            r.code = pli_pkg::ST_FEW;
            return r;
        end
        for (i = 1; i < n - 1; i++)
            if (q <= (by_y ? y_points[i] : x_points[i]))
                break;
        k1 = by_y ? y_points[i-1] : x_points[i-1];
        k2 = by_y ? y_points[i] : x_points[i];
        v1 = by_y ? x_points[i-1] : y_points[i-1];
        v2 = by_y ? x_points[i] : y_points[i];
        dk = k2 - k1;
        if (dk == 0)
        begin
            r.code = pli_pkg::ST_ZERO_SEG;
            r.value = 32'(v1);
            return r;
        end
        a = longint'(q) - k1;
        b = v2 - v1;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        md = (dk < 0) ? -dk : dk;
        mq = (ma * mb + md / 2) / md;
        neg = ((a < 0) != (b < 0)) != (dk < 0);
        if (mq > (64'd1 << 33))
        begin
            r.code = pli_pkg::ST_SATURATED;
            r.value = neg ? 32'sh80000000 : 32'sh7fffffff;
            return r;
        end
        t = neg ? v1 - longint'(mq) : v1 + longint'(mq);
        if (t > 64'sd2147483647)
        begin
            r.code = pli_pkg::ST_SATURATED;
            r.value = 32'sh7fffffff;
        end
        else if (t < -64'sd2147483648)
        begin
            r.code = pli_pkg::ST_SATURATED;
            r.value = 32'sh80000000;
        end
        else
            r.value = 32'(t);
        return r;
    endfunction

    // Config writes travel through the item queue so they happen only when idle.
    function automatic void push_cfg(int count);
        item_t it;
        it = '{default: 0};
        it.is_cfg = 1;
        it.cfg_count = 7'(count);
        pending_items.push_back(it);
    endfunction

    function automatic void push_write(int idx, logic signed [31:0] x, logic signed [31:0] y);
        item_t it;
        it = '{default: 0};
        it.mode = pli_pkg::MODE_WRITE;
        it.index = 6'(idx);
        it.px = x;
        it.py = y;
        pending_items.push_back(it);
    endfunction

    function automatic void push_query(logic [1:0] m, logic signed [31:0] q);
        item_t it;
        it = '{default: 0};
        it.mode = m;
        it.qv = q;
        it.index = 6'($urandom);
        it.px = $urandom;
        it.py = $urandom;
        pending_items.push_back(it);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        endcase
    endfunction

    // Builds a table of n points in non-decreasing x order, then queries it, with occasional point rewrites.
    function automatic void push_table_phase(int n, int queries);
        logic signed [31:0] x, y;
        x = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh01000000;
        y = rand_coord();
        for (int k = 0; k < n; k++)
        begin
            push_write(k, x, y);
            x = x + $urandom_range(0, 3) * $urandom_range(0, 32'h0003ffff);
            y = ($urandom_range(0, 7) == 0) ? rand_coord()
                : y + $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00010000;
        end
        push_cfg(n);
        for (int k = 0; k < queries; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_write($urandom_range(0, n - 1), rand_coord(), rand_coord());
            else
                push_query($urandom_range(0, 9) == 0 ? pli_pkg::MODE_UNUSED
                           : ($urandom_range(0, 1) ? pli_pkg::MODE_QUERY_X
                                                   : pli_pkg::MODE_QUERY_Y),
                           rand_coord());
        end
    endfunction

    initial
    begin
        // Directed: too few points, extremes, zero-width, saturation, unused mode.
        push_query(pli_pkg::MODE_QUERY_X, 0);
        push_query(pli_pkg::MODE_QUERY_Y, 32'sh7fffffff);
        push_write(0, 32'sh80000000, 32'sh7fffffff);
        push_write(1, 32'sh80000000, 32'sh80000000);
        push_write(2, 32'sh7fffffff, 0);
        push_write(63, 32'sh7fffffff, 32'sh7fffffff);
        push_cfg(1);
        push_query(pli_pkg::MODE_QUERY_X, 5);
        push_cfg(2);
        push_query(pli_pkg::MODE_QUERY_X, 0);
        push_query(pli_pkg::MODE_QUERY_Y, 0);
        push_cfg(3);
        push_query(pli_pkg::MODE_QUERY_X, 32'sh7fffffff);
        push_query(pli_pkg::MODE_QUERY_X, 32'sh80000000);
        push_query(pli_pkg::MODE_QUERY_Y, 32'sh80000000);
        push_query(pli_pkg::MODE_UNUSED, 1);
        push_write(0, 0, 0);
        push_write(1, 32'sh00010000, 32'sh7fffffff);
        push_write(2, 32'sh00020000, 32'sh80000000);
        push_query(pli_pkg::MODE_QUERY_X, 32'sh7fffffff);
        push_query(pli_pkg::MODE_QUERY_X, 32'sh80000000);
        push_query(pli_pkg::MODE_QUERY_Y, 32'sh00008000);
        for (int k = 3; k < pli_pkg::MAX_POINTS; k++)
            push_write(k, k << 17, -k);
        push_cfg(127);
        push_query(pli_pkg::MODE_QUERY_X, 32'sh7fffffff);
        push_query(pli_pkg::MODE_QUERY_Y, -5);
        push_cfg(64);
        push_query(pli_pkg::MODE_QUERY_X, 32'sh00300000);
        while (pending_items.size() < 1500)
        begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? pli_pkg::MAX_POINTS : $urandom_range(2, 10);
            push_table_phase(n, $urandom_range(20, 60));
        end
        push_cfg(0);
        push_query(pli_pkg::MODE_QUERY_Y, 1);
        stimulus_done = 1;
    end

    // Sender: one gap per item, config writes only once the block has drained.
    typedef enum int { S_IDLE, S_OFFER, S_DRAIN, S_SETUP, S_ACCESS } drive_state_t;
    drive_state_t drive_state = S_IDLE;
    item_t cur;
    int gap = 0;
    int drain = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            case (drive_state)
                S_IDLE:
                    if (gap > 0)
                        gap <= gap - 1;
                    else if (pending_items.size() > 0)
                    begin
                        cur = pending_items.pop_front();
                        if (cur.is_cfg)
                        begin
                            drive_state <= S_DRAIN;
                            drain <= 120;
                        end
                        else
                        begin
                            in_valid <= 1'b1;
                            mode <= cur.mode;
                            point_index <= cur.index;
                            point_x <= cur.px;
                            point_y <= cur.py;
                            query_value <= cur.qv;
                            drive_state <= S_OFFER;
                        end
                    end
                S_OFFER:
                    if (!in_stall)
                    begin
                        if (cur.mode == pli_pkg::MODE_WRITE)
                        begin
                            x_points[cur.index] = cur.px;
                            y_points[cur.index] = cur.py;
                            writes_sent++;
                        end
                        else if (cur.mode != pli_pkg::MODE_UNUSED)
                            expected_lookups.push_back(
                                interpolate(cur.mode == pli_pkg::MODE_QUERY_Y, cur.qv));
                        in_valid <= 1'b0;
                        gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
                        drive_state <= S_IDLE;
                    end
                S_DRAIN:
                    if (expected_lookups.size() > 0)
                        drain <= 120;
                    else if (drain > 0)
                        drain <= drain - 1;
                    else
                    begin
                        psel <= 1'b1;
                        pwrite <= 1'b1;
                        paddr <= pli_pkg::ADDR_POINT_COUNT;
                        pwdata <= 32'(cur.cfg_count);
                        drive_state <= S_SETUP;
                    end
                S_SETUP:
                begin
                    penable <= 1'b1;
                    drive_state <= S_ACCESS;
                end
                S_ACCESS:
                    if (pready)
                    begin
                        active_count = cur.cfg_count;
                        psel <= 1'b0;
                        penable <= 1'b0;
                        pwrite <= 1'b0;
                        drive_state <= S_IDLE;
                    end
                default:
                    drive_state <= S_IDLE;
            endcase
        end
    end

    // Receiver stall pattern, with one long hold-off so the block backs up its input.
    int stall_wait = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off == 0 && queries_checked == 40)
            begin
                hold_off <= 1;
                stall_wait <= 600;
                out_stall <= 1'b1;
            end
            else if (stall_wait > 0)
                stall_wait <= stall_wait - 1;
            else if (out_valid && !out_stall)
            begin
                stall_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        lookup_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d status=%0d",
                         $realtime, result_value, status);
                errors++;
            end
            else
            begin
                exp_r = expected_lookups.pop_front();
                if (result_value !== exp_r.value)
                begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $realtime, exp_r.value, result_value);
                    errors++;
                end
                if (status !== exp_r.code)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, exp_r.code, status);
                    errors++;
                end
                queries_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == 2000000)
        begin
            $display("timeout with %0d results outstanding", expected_lookups.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        active_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done);
        wait (pending_items.size() == 0 && drive_state == S_IDLE && gap == 0
              && expected_lookups.size() == 0);
        repeat (150) @(posedge clk);
        $display("Checked %0d lookups and sent %0d table writes.", queries_checked,
                 writes_sent);
        if (errors == 0 && expected_lookups.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### files.f
sv/pli_pkg.sv
sv/pli_div.sv
sv/piecewise_linear_interpolator.sv
tb/piecewise_linear_interpolator_test.sv
